[hw/rtl/cbce_pkg.sv]
// Shared types, constants and helpers for the clipped bit-plane colour expander.
package cbce_pkg;

   // Size limits
   localparam int MAX_SIDE     = 4096;
   localparam int MAX_PLANES   = 4;
   localparam int QUEUE_DEPTH  = 4;

   // Field widths
   localparam int SIDE_W       = 13;
   localparam int COORD_W      = 16;
   localparam int WIN_POS_W    = 12;
   localparam int COLOR_W      = 16;
   localparam int PIX_PER_BYTE = 8;
   localparam int BPR_W        = 10;
   localparam int PLANE_CNT_W  = 3;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int CLIP_W       = 18;

   localparam logic [SIDE_W-1:0]      SIDE_MAX   = SIDE_W'(MAX_SIDE);
   localparam logic [PLANE_CNT_W-1:0] PLANES_MAX = PLANE_CNT_W'(MAX_PLANES);

   // Reset values of the control registers
   localparam logic [SIDE_W-1:0]  RST_SCREEN_WIDTH  = 13'd320;
   localparam logic [SIDE_W-1:0]  RST_SCREEN_HEIGHT = 13'd240;
   localparam logic [COLOR_W-1:0] RST_BACKGROUND    = 16'h0000;
   localparam logic [COLOR_W-1:0] RST_PLANE_COLOR   = 16'hFFFF;

   // Control register indexes
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_SCREEN_WIDTH  = 3'd0;
   localparam csr_index_type CSR_SCREEN_HEIGHT = 3'd1;
   localparam csr_index_type CSR_BACKGROUND    = 3'd2;
   localparam csr_index_type CSR_PLANE0_COLOR  = 3'd3;
   localparam csr_index_type CSR_PLANE1_COLOR  = 3'd4;
   localparam csr_index_type CSR_PLANE2_COLOR  = 3'd5;
   localparam csr_index_type CSR_PLANE3_COLOR  = 3'd6;

   // Command and result kind codes
   localparam logic CMD_BEGIN   = 1'b0;
   localparam logic CMD_DATA    = 1'b1;
   localparam logic KIND_WINDOW = 1'b0;
   localparam logic KIND_PIXEL  = 1'b1;

   typedef struct packed {
      logic [SIDE_W-1:0]                    screen_width;
      logic [SIDE_W-1:0]                    screen_height;
      logic [COLOR_W-1:0]                   background_color;
      logic [MAX_PLANES-1:0][COLOR_W-1:0]   plane_color;
   } cfg_type;

   // One queue entry: a window result or up to eight pixels of one byte.
   // Pixel bit b of each vector is the b-th pixel from the left.
   typedef struct packed {
      logic                                   kind;
      logic                                   visible;
      logic [WIN_POS_W-1:0]                   win_x;
      logic [WIN_POS_W-1:0]                   win_y;
      logic [SIDE_W-1:0]                      win_w;
      logic [SIDE_W-1:0]                      win_h;
      logic [MAX_PLANES-1:0][PIX_PER_BYTE-1:0] plane_bits;
      logic [PIX_PER_BYTE-1:0]                pix_mask;
      logic [PIX_PER_BYTE-1:0]                end_mask;
      logic                                   last_row;
   } job_type;

   typedef struct packed {
      logic                 kind;
      logic                 visible;
      logic [WIN_POS_W-1:0] win_x;
      logic [WIN_POS_W-1:0] win_y;
      logic [SIDE_W-1:0]    win_w;
      logic [SIDE_W-1:0]    win_h;
      logic [COLOR_W-1:0]   pixel_color;
      logic                 row_end;
      logic                 image_end;
      logic                 run_last;
   } rsp_type;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
      return (v > SIDE_MAX) ? SIDE_MAX : v;
   endfunction

endpackage

[hw/rtl/clipped_bitplane_color_expander.sv]
// Top level of the clipped bit-plane colour expander: control registers and block wiring.
//
//   channel  direction  handshake          beat
//   req_     in         push / full        begin (cmd 0) or one byte per plane (cmd 1)
//   rsp_     out        empty / pop        one window or pixel result
//   csr_     in         wen                write of one control register
//
// The front takes one request beat per cycle while the work queue has room. The back
// sends one result beat per cycle while the result consumer keeps up, one beat per
// on-screen pixel of a data byte, 1 to 8; a byte with none leaves no entry.
// Reset clears the queue, the result register and the drawing state and loads
// the register defaults. A stalled result consumer backs up into the queue;
// full rises only when all QUEUE_DEPTH entries are taken.
module clipped_bitplane_color_expander #(
   parameter int QUEUE_DEPTH = cbce_pkg::QUEUE_DEPTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic                                     req_cmd,
   input  logic signed [cbce_pkg::COORD_W-1:0]      req_pos_x,
   input  logic signed [cbce_pkg::COORD_W-1:0]      req_pos_y,
   input  logic [cbce_pkg::SIDE_W-1:0]              req_bm_width,
   input  logic [cbce_pkg::SIDE_W-1:0]              req_bm_height,
   input  logic [cbce_pkg::PLANE_CNT_W-1:0]         req_plane_count,
   input  logic [cbce_pkg::PIX_PER_BYTE-1:0]        req_plane0_byte,
   input  logic [cbce_pkg::PIX_PER_BYTE-1:0]        req_plane1_byte,
   input  logic [cbce_pkg::PIX_PER_BYTE-1:0]        req_plane2_byte,
   input  logic [cbce_pkg::PIX_PER_BYTE-1:0]        req_plane3_byte,
   // result channel
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output logic                                     rsp_kind,
   output logic                                     rsp_visible,
   output logic [cbce_pkg::WIN_POS_W-1:0]           rsp_win_x,
   output logic [cbce_pkg::WIN_POS_W-1:0]           rsp_win_y,
   output logic [cbce_pkg::SIDE_W-1:0]              rsp_win_w,
   output logic [cbce_pkg::SIDE_W-1:0]              rsp_win_h,
   output logic [cbce_pkg::COLOR_W-1:0]             rsp_pixel_color,
   output logic                                     rsp_row_end,
   output logic                                     rsp_image_end,
   output logic                                     rsp_run_last,
   // control register port
   input  logic                                     csr_wen,
   input  logic [cbce_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [cbce_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int SW = cbce_pkg::SIDE_W;
   localparam int CL = cbce_pkg::COLOR_W;

   cbce_pkg::cfg_type cfg_ff, cfg_in;
   cbce_pkg::job_type q_wdata, q_rdata;
   cbce_pkg::rsp_type rsp;
   logic              q_push, q_pop, q_full, q_empty, accept;
   logic [cbce_pkg::MAX_PLANES-1:0][cbce_pkg::PIX_PER_BYTE-1:0] plane_bytes;

   // control registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            cbce_pkg::CSR_SCREEN_WIDTH:  cfg_in.screen_width     = csr_wdata[SW-1:0];
            cbce_pkg::CSR_SCREEN_HEIGHT: cfg_in.screen_height    = csr_wdata[SW-1:0];
            cbce_pkg::CSR_BACKGROUND:    cfg_in.background_color = csr_wdata[CL-1:0];
            cbce_pkg::CSR_PLANE0_COLOR:  cfg_in.plane_color[0]   = csr_wdata[CL-1:0];
            cbce_pkg::CSR_PLANE1_COLOR:  cfg_in.plane_color[1]   = csr_wdata[CL-1:0];
            cbce_pkg::CSR_PLANE2_COLOR:  cfg_in.plane_color[2]   = csr_wdata[CL-1:0];
            cbce_pkg::CSR_PLANE3_COLOR:  cfg_in.plane_color[3]   = csr_wdata[CL-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width     <= cbce_pkg::RST_SCREEN_WIDTH;
         cfg_ff.screen_height    <= cbce_pkg::RST_SCREEN_HEIGHT;
         cfg_ff.background_color <= cbce_pkg::RST_BACKGROUND;
         cfg_ff.plane_color      <= {cbce_pkg::MAX_PLANES{cbce_pkg::RST_PLANE_COLOR}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   assign plane_bytes[0] = req_plane0_byte;
   assign plane_bytes[1] = req_plane1_byte;
   assign plane_bytes[2] = req_plane2_byte;
   assign plane_bytes[3] = req_plane3_byte;

   cbce_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .cmd         (req_cmd),
      .pos_x       (req_pos_x),
      .pos_y       (req_pos_y),
      .bm_width    (req_bm_width),
      .bm_height   (req_bm_height),
      .plane_count (req_plane_count),
      .plane_bytes (plane_bytes),
      .q_push      (q_push),
      .q_data      (q_wdata)
   );

   cbce_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   cbce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_kind        = rsp.kind;
   assign rsp_visible     = rsp.visible;
   assign rsp_win_x       = rsp.win_x;
   assign rsp_win_y       = rsp.win_y;
   assign rsp_win_w       = rsp.win_w;
   assign rsp_win_h       = rsp.win_h;
   assign rsp_pixel_color = rsp.pixel_color;
   assign rsp_row_end     = rsp.row_end;
   assign rsp_image_end   = rsp.image_end;
   assign rsp_run_last    = rsp.run_last;

endmodule

[hw/rtl/cbce_queue.sv]
// Short first-in first-out queue of work entries between front and back.
module cbce_queue #(
   parameter int DEPTH = cbce_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cbce_pkg::job_type wdata,
   output logic              full,
   input  logic              pop,
   output cbce_pkg::job_type rdata,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   cbce_pkg::job_type  mem [DEPTH];
   cbce_pkg::job_type  rdata_ff;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = rdata_ff;

   // pointer and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   // head entry, read at the next head address; a beat written into an emptying queue
   // goes straight through
   always_ff @(posedge clock) begin
      if (do_push && (wr_ptr_ff == rd_ptr_in)) begin
         rdata_ff <= wdata;
      end else begin
         rdata_ff <= mem[rd_ptr_in];
      end
   end

endmodule

[hw/rtl/cbce_front.sv]
// Front end: clips begin beats, tracks the source position and classifies data bytes.
module cbce_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cbce_pkg::cfg_type                      cfg,
   input  logic                                   accept,
   input  logic                                   cmd,
   input  logic signed [cbce_pkg::COORD_W-1:0]    pos_x,
   input  logic signed [cbce_pkg::COORD_W-1:0]    pos_y,
   input  logic [cbce_pkg::SIDE_W-1:0]            bm_width,
   input  logic [cbce_pkg::SIDE_W-1:0]            bm_height,
   input  logic [cbce_pkg::PLANE_CNT_W-1:0]       plane_count,
   input  logic [cbce_pkg::MAX_PLANES-1:0][cbce_pkg::PIX_PER_BYTE-1:0] plane_bytes,
   output logic                                   q_push,
   output cbce_pkg::job_type                      q_data
);

   localparam int SW = cbce_pkg::SIDE_W;
   localparam int CW = cbce_pkg::CLIP_W;
   localparam int PB = cbce_pkg::PIX_PER_BYTE;
   localparam int BW = cbce_pkg::BPR_W;
   localparam int PW = cbce_pkg::PLANE_CNT_W;
   localparam int NP = cbce_pkg::MAX_PLANES;

   // drawing state
   logic          active_ff, active_in;
   logic [SW-1:0] row_ff, row_in;
   logic [BW-1:0] byte_col_ff, byte_col_in;
   logic [BW-1:0] bpr_ff, bpr_in;
   logic [SW-1:0] col_first_ff, col_first_in;
   logic [SW-1:0] col_last_ff, col_last_in;
   logic [SW-1:0] row_first_ff, row_first_in;
   logic [SW-1:0] row_last_ff, row_last_in;
   logic [PW-1:0] planes_ff, planes_in;

   // begin clipping
   logic [SW-1:0]        w_c, h_c, sw_c, sh_c;
   logic signed [CW-1:0] x_s, y_s, cf_s, rf_s, cl_s, rl_s;
   logic signed [CW-1:0] cl_a, cl_b, rl_a, rl_b;
   logic signed [CW-1:0] wx_s, wy_s, ww_s, wh_s;
   logic                 win_vis;
   logic [PW-1:0]        pc_c;
   logic [SW:0]          bpr_sum;

   always_comb begin
      x_s  = CW'(pos_x);
      y_s  = CW'(pos_y);
      w_c  = cbce_pkg::clamp_side(bm_width);
      h_c  = cbce_pkg::clamp_side(bm_height);
      sw_c = cbce_pkg::clamp_side(cfg.screen_width);
      sh_c = cbce_pkg::clamp_side(cfg.screen_height);
      cf_s = x_s[CW-1] ? -x_s : '0;
      rf_s = y_s[CW-1] ? -y_s : '0;
      cl_a = $signed({{(CW-SW){1'b0}}, w_c}) - CW'(1);
      cl_b = $signed({{(CW-SW){1'b0}}, sw_c}) - CW'(1) - x_s;
      rl_a = $signed({{(CW-SW){1'b0}}, h_c}) - CW'(1);
      rl_b = $signed({{(CW-SW){1'b0}}, sh_c}) - CW'(1) - y_s;
      cl_s = (cl_b < cl_a) ? cl_b : cl_a;
      rl_s = (rl_b < rl_a) ? rl_b : rl_a;
      win_vis = (cf_s <= cl_s) && (rf_s <= rl_s);
      wx_s = x_s + cf_s;
      wy_s = y_s + rf_s;
      ww_s = cl_s - cf_s + CW'(1);
      wh_s = rl_s - rf_s + CW'(1);
      // plane count limited to one .. MAX_PLANES
      if (plane_count == '0) begin
         pc_c = PW'(1);
      end else if (plane_count > cbce_pkg::PLANES_MAX) begin
         pc_c = cbce_pkg::PLANES_MAX;
      end else begin
         pc_c = plane_count;
      end
      bpr_sum = {1'b0, w_c} + (SW+1)'(PB - 1);
   end

   // data byte classification
   logic [SW-1:0]          col_base, col_b;
   logic [PB-1:0]          vis_col, end_col, pix_mask;
   logic [NP-1:0][PB-1:0]  pbits;
   logic                   row_vis, on_last_row, finished, col_wrap;
   logic [SW-1:0]          row_next;

   always_comb begin
      col_base = {byte_col_ff, 3'b000};
      for (int b = 0; b < PB; b++) begin
         col_b      = col_base + SW'(b);
         vis_col[b] = (col_b >= col_first_ff) && (col_b <= col_last_ff);
         end_col[b] = (col_b == col_last_ff);
      end
      // reorder so that bit b is the b-th pixel from the left; unused planes read as clear
      for (int k = 0; k < NP; k++) begin
         for (int b = 0; b < PB; b++) begin
            pbits[k][b] = (PW'(k) < planes_ff) ? plane_bytes[k][PB-1-b] : 1'b0;
         end
      end
      row_vis     = (row_ff >= row_first_ff) && (row_ff <= row_last_ff);
      on_last_row = (row_ff == row_last_ff);
      pix_mask    = row_vis ? vis_col : '0;
      finished    = row_vis && on_last_row && (|end_col);
      col_wrap    = ({1'b0, byte_col_ff} + (BW+1)'(1)) >= {1'b0, bpr_ff};
      row_next    = col_wrap ? row_ff + SW'(1) : row_ff;
   end

   // next state
   always_comb begin
      active_in    = active_ff;
      row_in       = row_ff;
      byte_col_in  = byte_col_ff;
      bpr_in       = bpr_ff;
      col_first_in = col_first_ff;
      col_last_in  = col_last_ff;
      row_first_in = row_first_ff;
      row_last_in  = row_last_ff;
      planes_in    = planes_ff;
      if (accept && cmd == cbce_pkg::CMD_BEGIN) begin
         active_in = win_vis;
         if (win_vis) begin
            row_in       = '0;
            byte_col_in  = '0;
            bpr_in       = bpr_sum[SW-1:3];
            col_first_in = cf_s[SW-1:0];
            col_last_in  = cl_s[SW-1:0];
            row_first_in = rf_s[SW-1:0];
            row_last_in  = rl_s[SW-1:0];
            planes_in    = pc_c;
         end
      end else if (accept && active_ff) begin
         byte_col_in = col_wrap ? '0 : byte_col_ff + BW'(1);
         row_in      = row_next;
         if (finished || row_next > row_last_ff) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         row_ff       <= '0;
         byte_col_ff  <= '0;
         bpr_ff       <= '0;
         col_first_ff <= '0;
         col_last_ff  <= '0;
         row_first_ff <= '0;
         row_last_ff  <= '0;
         planes_ff    <= PW'(1);
      end else begin
         active_ff    <= active_in;
         row_ff       <= row_in;
         byte_col_ff  <= byte_col_in;
         bpr_ff       <= bpr_in;
         col_first_ff <= col_first_in;
         col_last_ff  <= col_last_in;
         row_first_ff <= row_first_in;
         row_last_ff  <= row_last_in;
         planes_ff    <= planes_in;
      end
   end

   // queue entry
   always_comb begin
      q_data = '0;
      if (cmd == cbce_pkg::CMD_BEGIN) begin
         q_data.kind    = cbce_pkg::KIND_WINDOW;
         q_data.visible = win_vis;
         if (win_vis) begin
            q_data.win_x = wx_s[cbce_pkg::WIN_POS_W-1:0];
            q_data.win_y = wy_s[cbce_pkg::WIN_POS_W-1:0];
            q_data.win_w = ww_s[SW-1:0];
            q_data.win_h = wh_s[SW-1:0];
         end
         q_push = accept;
      end else begin
         q_data.kind       = cbce_pkg::KIND_PIXEL;
         q_data.plane_bits = pbits;
         q_data.pix_mask   = pix_mask;
         q_data.end_mask   = end_col & pix_mask;
         q_data.last_row   = on_last_row;
         // stray bytes and bytes with nothing on screen leave no entry
         q_push = accept && active_ff && (pix_mask != '0);
      end
   end

endmodule

[hw/rtl/cbce_back.sv]
// Back end: expands entries into result beats, one pixel per cycle when not stalled.
module cbce_back (
   input  logic              clock,
   input  logic              reset,
   input  cbce_pkg::cfg_type cfg,
   input  logic              q_empty,
   input  cbce_pkg::job_type q_rdata,
   output logic              q_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output cbce_pkg::rsp_type rsp
);

   localparam int PB = cbce_pkg::PIX_PER_BYTE;
   localparam int NP = cbce_pkg::MAX_PLANES;

   cbce_pkg::job_type job_ff, job_in;
   logic              job_valid_ff, job_valid_in;
   cbce_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [PB-1:0]                 sel, rest;
   logic [cbce_pkg::COLOR_W-1:0]  color;
   logic                          out_ready, step, last, row_end;

   // leftmost pending pixel and its colour; later planes win
   always_comb begin
      sel   = job_ff.pix_mask & (~job_ff.pix_mask + PB'(1));
      rest  = job_ff.pix_mask & ~sel;
      color = cfg.background_color;
      for (int k = 0; k < NP; k++) begin
         if (|(sel & job_ff.plane_bits[k])) begin
            color = cfg.plane_color[k];
         end
      end
      row_end = |(sel & job_ff.end_mask);
   end

   assign out_ready = !rsp_valid_ff || rsp_pop;
   assign step      = job_valid_ff && out_ready;
   assign last      = (job_ff.kind == cbce_pkg::KIND_WINDOW) || (rest == '0);
   assign q_pop     = !q_empty && (!job_valid_ff || (step && last));

   // result beat
   always_comb begin
      rsp_in = '0;
      if (job_ff.kind == cbce_pkg::KIND_WINDOW) begin
         rsp_in.kind     = cbce_pkg::KIND_WINDOW;
         rsp_in.visible  = job_ff.visible;
         rsp_in.win_x    = job_ff.win_x;
         rsp_in.win_y    = job_ff.win_y;
         rsp_in.win_w    = job_ff.win_w;
         rsp_in.win_h    = job_ff.win_h;
         rsp_in.run_last = 1'b1;
      end else begin
         rsp_in.kind        = cbce_pkg::KIND_PIXEL;
         rsp_in.pixel_color = color;
         rsp_in.row_end     = row_end;
         rsp_in.image_end   = row_end && job_ff.last_row;
         rsp_in.run_last    = last;
      end
   end

   // current entry
   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      if (q_pop) begin
         job_in       = q_rdata;
         job_valid_in = 1'b1;
      end else if (step && last) begin
         job_valid_in = 1'b0;
      end else if (step) begin
         job_in.pix_mask = rest;
      end
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
